// File: rtl/bbcs_pkg.sv
package bbcs_pkg;

    localparam int PACKET_LEN   = 16;
    localparam int REPLY_DEPTH  = 32;
    localparam int SYNC_RUN     = 6;
    localparam int ID_LEN       = 14;
    localparam int ID_REPLY_LEN = ID_LEN + 2;
    localparam int REG_DEPTH    = 16;

    localparam int RX_IDX_W    = $clog2(PACKET_LEN);
    localparam int RX_PTR_W    = $clog2(PACKET_LEN + 1);
    localparam int REPLY_IDX_W = $clog2(REPLY_DEPTH);
    localparam int REPLY_PTR_W = $clog2(REPLY_DEPTH + 1);
    localparam int REG_IDX_W   = $clog2(REG_DEPTH);
    localparam int SWEEP_MAX   = (ID_REPLY_LEN > PACKET_LEN) ? ID_REPLY_LEN : PACKET_LEN;
    localparam int SWEEP_W     = $clog2(SWEEP_MAX);
    localparam int FF_RUN_W    = 3;
    localparam int FF_RUN_MAX  = 7;

    localparam logic [7:0] SYNC_BYTE = 8'hFF;

    localparam logic [1:0] OP_UART  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    localparam logic [1:0] PH_TOP   = 2'd0;
    localparam logic [1:0] PH_RADDR = 2'd1;
    localparam logic [1:0] PH_WDATA = 2'd2;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_PING        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDENT       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REG_READ    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REG_WRITE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SONAR       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BOARD_RESET = 3'd5;

    typedef logic [7:0] t_byte;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] data;
    } t_in_item;

    typedef struct packed {
        logic [7:0] read_byte;
        logic       read_overrun;
        logic       reset_pulse;
    } t_out_item;

    typedef struct packed {
        logic latch;
        logic exec;
        logic sweep;
        logic load_out;
    } t_ctrl_cmd;

    typedef struct packed {
        logic start_sweep;
        logic sweep_last;
    } t_dp_status;

    function automatic t_byte ident_byte(input logic [SWEEP_W-1:0] idx);
        t_byte b;
        case (idx)
            SWEEP_W'(0):  b = 8'(ID_LEN);
            SWEEP_W'(1):  b = 8'h42;
            SWEEP_W'(2):  b = 8'h6C;
            SWEEP_W'(3):  b = 8'h61;
            SWEEP_W'(4):  b = 8'h63;
            SWEEP_W'(5):  b = 8'h6B;
            SWEEP_W'(6):  b = 8'h66;
            SWEEP_W'(7):  b = 8'h69;
            SWEEP_W'(8):  b = 8'h6E;
            SWEEP_W'(9):  b = 8'h20;
            SWEEP_W'(10): b = 8'h42;
            SWEEP_W'(11): b = 8'h6F;
            SWEEP_W'(12): b = 8'h61;
            SWEEP_W'(13): b = 8'h72;
            SWEEP_W'(14): b = 8'h64;
            default:      b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

// File: rtl/bbcs_ctrl.sv
module bbcs_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    input  bbcs_pkg::t_dp_status  i_status,
    output bbcs_pkg::t_ctrl_cmd   o_cmd
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_EXEC   = 2'd1;
    localparam logic [1:0] S_SWEEP  = 2'd2;
    localparam logic [1:0] S_FINISH = 2'd3;

    logic [1:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       out_free;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign out_free    = !r_out_valid || i_out_ready;

    always_comb begin
        n_state        = r_state;
        o_cmd          = '0;
        o_cmd.latch    = (r_state == S_IDLE) && i_in_valid;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_EXEC;
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = i_status.start_sweep ? S_SWEEP : S_FINISH;
            end
            S_SWEEP: begin
                o_cmd.sweep = 1'b1;
                if (i_status.sweep_last) n_state = S_FINISH;
            end
            S_FINISH: begin
                if (out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (r_out_valid && i_out_ready) n_out_valid = 1'b0;
        if (o_cmd.load_out) n_out_valid = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// File: rtl/bbcs_dp.sv
module bbcs_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  bbcs_pkg::t_ctrl_cmd               i_cmd,
    output bbcs_pkg::t_dp_status              o_status,
    input  bbcs_pkg::t_in_item                i_in_item,
    output bbcs_pkg::t_out_item               o_out_item,
    input  logic                              i_cfg_we,
    input  logic [bbcs_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [7:0]                        i_cfg_data
);

    logic [1:0]                        r_op;
    bbcs_pkg::t_byte                   r_data;
    bbcs_pkg::t_byte                   r_code_ping, r_code_ident, r_code_reg_read;
    bbcs_pkg::t_byte                   r_code_reg_write, r_code_sonar, r_code_board_reset;
    logic [1:0]                        r_phase;
    logic                              r_param_seen;
    logic [bbcs_pkg::REG_IDX_W-1:0]    r_pend_addr;
    bbcs_pkg::t_byte                   r_reg_file [bbcs_pkg::REG_DEPTH];
    bbcs_pkg::t_byte                   r_reply_buf [bbcs_pkg::REPLY_DEPTH];
    logic [bbcs_pkg::REPLY_PTR_W-1:0]  r_reply_ptr;
    logic [bbcs_pkg::FF_RUN_W-1:0]     r_ff_run;
    logic [bbcs_pkg::RX_PTR_W-1:0]     r_rx_ptr;
    bbcs_pkg::t_byte                   r_rx_store [bbcs_pkg::PACKET_LEN];
    bbcs_pkg::t_byte                   r_snapshot [bbcs_pkg::PACKET_LEN];
    logic                              r_sweep_sonar;
    logic [bbcs_pkg::SWEEP_W-1:0]      r_sweep_cnt;
    bbcs_pkg::t_out_item               r_res;
    bbcs_pkg::t_out_item               r_out;

    logic                              top_level;
    logic                              is_write;
    logic                              sel_ping, sel_ident, sel_rr, sel_rw, sel_br, sel_sonar;
    bbcs_pkg::t_byte                   n_rx_store [bbcs_pkg::PACKET_LEN];
    logic [bbcs_pkg::RX_PTR_W-1:0]     ptr_inc;
    logic [bbcs_pkg::RX_PTR_W-1:0]     n_rx_ptr;
    logic [bbcs_pkg::FF_RUN_W-1:0]     n_ff_run;
    logic                              snap_take;
    bbcs_pkg::t_out_item               n_res;
    logic                              ptr_in_range;

    always_comb begin
        top_level = (r_phase != bbcs_pkg::PH_RADDR) && (r_phase != bbcs_pkg::PH_WDATA);
        is_write  = (r_op == bbcs_pkg::OP_WRITE);
        sel_ping  = (r_data == r_code_ping);
        sel_ident = !sel_ping && (r_data == r_code_ident);
        sel_rr    = !sel_ping && !sel_ident && (r_data == r_code_reg_read);
        sel_rw    = !sel_ping && !sel_ident && !sel_rr && (r_data == r_code_reg_write);
        sel_br    = !sel_ping && !sel_ident && !sel_rr && !sel_rw
                    && (r_data == r_code_board_reset);
        sel_sonar = !sel_ping && !sel_ident && !sel_rr && !sel_rw && !sel_br
                    && (r_data == r_code_sonar);
    end

    assign o_status.start_sweep = is_write && top_level && (sel_ident || sel_sonar);
    assign o_status.sweep_last  = r_sweep_sonar
        ? (r_sweep_cnt == bbcs_pkg::SWEEP_W'(bbcs_pkg::PACKET_LEN - 1))
        : (r_sweep_cnt == bbcs_pkg::SWEEP_W'(bbcs_pkg::ID_REPLY_LEN - 1));

    always_comb begin
        n_rx_store = r_rx_store;
        ptr_inc    = r_rx_ptr;
        if (r_rx_ptr < bbcs_pkg::RX_PTR_W'(bbcs_pkg::PACKET_LEN)) begin
            n_rx_store[r_rx_ptr[bbcs_pkg::RX_IDX_W-1:0]] = r_data;
            ptr_inc = r_rx_ptr + bbcs_pkg::RX_PTR_W'(1);
        end
        snap_take = (ptr_inc >= bbcs_pkg::RX_PTR_W'(bbcs_pkg::PACKET_LEN));
        if (r_data == bbcs_pkg::SYNC_BYTE) begin
            n_ff_run = (r_ff_run < bbcs_pkg::FF_RUN_W'(bbcs_pkg::FF_RUN_MAX))
                ? r_ff_run + bbcs_pkg::FF_RUN_W'(1) : r_ff_run;
            n_rx_ptr = (n_ff_run >= bbcs_pkg::FF_RUN_W'(bbcs_pkg::SYNC_RUN))
                ? '0 : ptr_inc;
        end else begin
            n_ff_run = '0;
            n_rx_ptr = ptr_inc;
        end
    end

    always_comb begin
        ptr_in_range = (r_reply_ptr < bbcs_pkg::REPLY_PTR_W'(bbcs_pkg::REPLY_DEPTH));
        n_res        = '0;
        if (r_op == bbcs_pkg::OP_READ) begin
            if (ptr_in_range) begin
                n_res.read_byte = r_reply_buf[r_reply_ptr[bbcs_pkg::REPLY_IDX_W-1:0]];
            end else begin
                n_res.read_overrun = 1'b1;
            end
        end
        n_res.reset_pulse = is_write && top_level && sel_br;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op               <= bbcs_pkg::OP_UART;
            r_data             <= '0;
            r_code_ping        <= 8'd0;
            r_code_ident       <= 8'd1;
            r_code_reg_read    <= 8'd2;
            r_code_reg_write   <= 8'd3;
            r_code_sonar       <= 8'd4;
            r_code_board_reset <= 8'd5;
            r_phase            <= bbcs_pkg::PH_TOP;
            r_param_seen       <= 1'b0;
            r_pend_addr        <= '0;
            r_reply_ptr        <= '0;
            r_ff_run           <= '0;
            r_rx_ptr           <= '0;
            r_sweep_sonar      <= 1'b0;
            r_sweep_cnt        <= '0;
            r_res              <= '0;
            r_out              <= '0;
            for (int i = 0; i < bbcs_pkg::REG_DEPTH; i++) r_reg_file[i] <= '0;
            for (int i = 0; i < bbcs_pkg::REPLY_DEPTH; i++) r_reply_buf[i] <= '0;
            for (int i = 0; i < bbcs_pkg::PACKET_LEN; i++) begin
                r_rx_store[i] <= '0;
                r_snapshot[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    bbcs_pkg::CFG_PING:        r_code_ping        <= i_cfg_data;
                    bbcs_pkg::CFG_IDENT:       r_code_ident       <= i_cfg_data;
                    bbcs_pkg::CFG_REG_READ:    r_code_reg_read    <= i_cfg_data;
                    bbcs_pkg::CFG_REG_WRITE:   r_code_reg_write   <= i_cfg_data;
                    bbcs_pkg::CFG_SONAR:       r_code_sonar       <= i_cfg_data;
                    bbcs_pkg::CFG_BOARD_RESET: r_code_board_reset <= i_cfg_data;
                    default: ;
                endcase
            end

            if (i_cmd.latch) begin
                r_op   <= i_in_item.op;
                r_data <= i_in_item.data;
            end

            if (i_cmd.exec) begin
                r_res <= n_res;
                unique case (r_op)
                    bbcs_pkg::OP_UART: begin
                        r_rx_store <= n_rx_store;
                        if (snap_take) r_snapshot <= n_rx_store;
                        r_ff_run <= n_ff_run;
                        r_rx_ptr <= n_rx_ptr;
                    end
                    bbcs_pkg::OP_WRITE: begin
                        r_reply_ptr <= '0;
                        priority if (r_phase == bbcs_pkg::PH_RADDR) begin
                            r_param_seen   <= 1'b0;
                            r_phase        <= bbcs_pkg::PH_TOP;
                            r_reply_buf[0] <= 8'd1;
                            r_reply_buf[1] <= r_reg_file[r_data[bbcs_pkg::REG_IDX_W-1:0]];
                        end else if (r_phase == bbcs_pkg::PH_WDATA) begin
                            if (!r_param_seen) begin
                                r_pend_addr  <= r_data[bbcs_pkg::REG_IDX_W-1:0];
                                r_param_seen <= 1'b1;
                            end else begin
                                r_param_seen            <= 1'b0;
                                r_phase                 <= bbcs_pkg::PH_TOP;
                                r_reg_file[r_pend_addr] <= r_data;
                            end
                        end else if (sel_ping) begin
                            r_reply_buf[0] <= 8'd0;
                        end else if (sel_ident) begin
                            r_sweep_sonar <= 1'b0;
                            r_sweep_cnt   <= '0;
                        end else if (sel_rr) begin
                            r_phase      <= bbcs_pkg::PH_RADDR;
                            r_param_seen <= 1'b0;
                        end else if (sel_rw) begin
                            r_phase      <= bbcs_pkg::PH_WDATA;
                            r_param_seen <= 1'b0;
                        end else if (sel_sonar) begin
                            r_reply_buf[0] <= 8'(bbcs_pkg::PACKET_LEN);
                            r_sweep_sonar  <= 1'b1;
                            r_sweep_cnt    <= '0;
                        end
                    end
                    bbcs_pkg::OP_READ: begin
                        if (ptr_in_range) r_reply_ptr <= r_reply_ptr + bbcs_pkg::REPLY_PTR_W'(1);
                    end
                    default: ;
                endcase
            end

            if (i_cmd.sweep) begin
                if (r_sweep_sonar) begin
                    r_reply_buf[bbcs_pkg::REPLY_IDX_W'(r_sweep_cnt) + bbcs_pkg::REPLY_IDX_W'(1)]
                        <= r_snapshot[r_sweep_cnt[bbcs_pkg::RX_IDX_W-1:0]];
                end else begin
                    r_reply_buf[bbcs_pkg::REPLY_IDX_W'(r_sweep_cnt)]
                        <= bbcs_pkg::ident_byte(r_sweep_cnt);
                end
                r_sweep_cnt <= r_sweep_cnt + bbcs_pkg::SWEEP_W'(1);
            end

            if (i_cmd.load_out) r_out <= r_res;
        end
    end

    assign o_out_item = r_out;

endmodule

// File: rtl/byte_bus_command_slave.sv
// Byte-wide bus slave that takes one transaction at a time: a UART byte, a byte
// written by the bus master, or a byte read by the bus master, each producing one
// result transaction. For UART bytes, plain commands, register accesses and reads the
// result is registered at the output after the execute and finish states; for the identity and
// sonar commands a sweep state lies between them, in which the reply buffer is filled one
// byte per cycle through its single write port. A result is registered only once the
// output is free, and the next transaction is accepted in the cycle after that, even while
// that result still waits at the output, so no transaction is taken while another is
// still in flight.
module byte_bus_command_slave (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  bbcs_pkg::t_in_item             i_in_item,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output bbcs_pkg::t_out_item            o_out_item,
    input  logic                           i_cfg_we,
    input  logic [bbcs_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [7:0]                     i_cfg_data
);

    bbcs_pkg::t_ctrl_cmd  cmd;
    bbcs_pkg::t_dp_status status;

    bbcs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    bbcs_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_status   (status),
        .i_in_item  (i_in_item),
        .o_out_item (o_out_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("transaction accepted while another is in flight");

    a_overrun_reads_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.read_overrun |-> o_out_item.read_byte == 8'd0)
        else $error("overrun result carries a nonzero byte");

    a_pulse_not_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_item.read_overrun && o_out_item.reset_pulse))
        else $error("reset pulse and overrun in the same result");

endmodule

// File: verif/testbench.sv
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] OP_NONE = 2'd3;
    localparam int NUM_CODES = 6;
    localparam int ITEM_TARGET = 700;
    localparam int QUIET_LIMIT = 2000;
    localparam int TAIL_CYCLES = 25;
    localparam logic [8*bbcs_pkg::ID_LEN-1:0] ID_TEXT = 112'h426C61636B66696E20426F617264;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_in_valid = 1'b0;
    logic                           o_in_ready;
    bbcs_pkg::t_in_item             i_in_item = '0;
    logic                           o_out_valid;
    logic                           i_out_ready = 1'b0;
    bbcs_pkg::t_out_item            o_out_item;
    logic                           i_cfg_we = 1'b0;
    logic [bbcs_pkg::CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [7:0]                     i_cfg_data = '0;

    // Expected behavior of the slave, kept in step with every accepted transaction.
    bbcs_pkg::t_byte cmd_code [NUM_CODES];
    logic [1:0]      phase;
    logic            arg_seen;
    logic [3:0]      wr_addr;
    bbcs_pkg::t_byte regs [bbcs_pkg::REG_DEPTH];
    bbcs_pkg::t_byte reply_mem [bbcs_pkg::REPLY_DEPTH];
    int              reply_rd;
    int              ff_count;
    int              rx_fill;
    bbcs_pkg::t_byte rx_mem [bbcs_pkg::PACKET_LEN];
    bbcs_pkg::t_byte sonar_snap [bbcs_pkg::PACKET_LEN];

    bbcs_pkg::t_out_item awaited_responses [$];
    bbcs_pkg::t_out_item head;
    int                  fail_count = 0;
    int                  sent_items = 0;
    int                  quiet_cycles = 0;
    logic [7:0]          stall_tick = '0;
    logic                burst_open = 1'b0;
    int                  burst_left = 1;

    byte_bus_command_slave dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic bbcs_pkg::t_out_item bus_response(input bbcs_pkg::t_in_item it);
        bbcs_pkg::t_out_item r;
        int k;
        r = '0;
        case (it.op)
            bbcs_pkg::OP_UART: begin
                if (rx_fill < bbcs_pkg::PACKET_LEN) begin
                    rx_mem[rx_fill] = it.data;
                    rx_fill++;
                end
                if (rx_fill >= bbcs_pkg::PACKET_LEN) begin
                    for (k = 0; k < bbcs_pkg::PACKET_LEN; k++) begin
                        sonar_snap[k] = rx_mem[k];
                    end
                end
                if (it.data == bbcs_pkg::SYNC_BYTE) begin
                    if (ff_count < bbcs_pkg::FF_RUN_MAX) begin
                        ff_count++;
                    end
                    if (ff_count >= bbcs_pkg::SYNC_RUN) begin
                        rx_fill = 0;
                    end
                end else begin
                    ff_count = 0;
                end
            end
            bbcs_pkg::OP_WRITE: begin
                reply_rd = 0;
                if (phase == bbcs_pkg::PH_RADDR) begin
                    arg_seen = 1'b0;
                    phase = bbcs_pkg::PH_TOP;
                    reply_mem[0] = 8'h01;
                    reply_mem[1] = regs[it.data[3:0]];
                end else if (phase == bbcs_pkg::PH_WDATA) begin
                    if (!arg_seen) begin
                        wr_addr = it.data[3:0];
                        arg_seen = 1'b1;
                    end else begin
                        arg_seen = 1'b0;
                        phase = bbcs_pkg::PH_TOP;
                        regs[wr_addr] = it.data;
                    end
                end else if (it.data == cmd_code[bbcs_pkg::CFG_PING]) begin
                    reply_mem[0] = 8'h00;
                end else if (it.data == cmd_code[bbcs_pkg::CFG_IDENT]) begin
                    reply_mem[0] = 8'(bbcs_pkg::ID_LEN);
                    for (k = 0; k < bbcs_pkg::ID_LEN; k++) begin
                        reply_mem[k + 1] = ID_TEXT[8 * (bbcs_pkg::ID_LEN - 1 - k) +: 8];
                    end
                    reply_mem[bbcs_pkg::ID_LEN + 1] = 8'h00;
                end else if (it.data == cmd_code[bbcs_pkg::CFG_REG_READ]) begin
                    phase = bbcs_pkg::PH_RADDR;
                    arg_seen = 1'b0;
                end else if (it.data == cmd_code[bbcs_pkg::CFG_REG_WRITE]) begin
                    phase = bbcs_pkg::PH_WDATA;
                    arg_seen = 1'b0;
                end else if (it.data == cmd_code[bbcs_pkg::CFG_BOARD_RESET]) begin
                    r.reset_pulse = 1'b1;
                end else if (it.data == cmd_code[bbcs_pkg::CFG_SONAR]) begin
                    for (k = 0; k < bbcs_pkg::PACKET_LEN; k++) begin
                        reply_mem[k + 1] = sonar_snap[k];
                    end
                    reply_mem[0] = 8'(bbcs_pkg::PACKET_LEN);
                end
            end
            bbcs_pkg::OP_READ: begin
                if (reply_rd < bbcs_pkg::REPLY_DEPTH) begin
                    r.read_byte = reply_mem[reply_rd];
                    reply_rd++;
                end else begin
                    r.read_overrun = 1'b1;
                end
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    task automatic send_item(input logic [1:0] op, input bbcs_pkg::t_byte data);
        bbcs_pkg::t_in_item it;
        int gap;
        it.op = op;
        it.data = data;
        if (!burst_open) begin
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item <= it;
        burst_open = 1'b1;
        @(posedge i_clk);
        while (!o_in_ready) begin
            @(posedge i_clk);
        end
        awaited_responses.push_back(bus_response(it));
        sent_items++;
        @(negedge i_clk);
        burst_left--;
        if (burst_left <= 0) begin
            i_in_valid <= 1'b0;
            burst_open = 1'b0;
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 12) : $urandom_range(0, 3);
            repeat (gap) begin
                @(negedge i_clk);
            end
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
        end
    endtask

    task automatic drain_responses();
        if (burst_open) begin
            i_in_valid <= 1'b0;
            burst_open = 1'b0;
        end
        while (awaited_responses.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic cfg_write(input logic [bbcs_pkg::CFG_IDX_W-1:0] idx,
                             input bbcs_pkg::t_byte val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        if (idx <= bbcs_pkg::CFG_BOARD_RESET) begin
            cmd_code[idx] = val;
        end
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Sends one command as currently coded (a random byte for kind NUM_CODES), its parameter bytes and a run of reads.
    task automatic issue_command(input int kind);
        bbcs_pkg::t_byte code;
        int reads;
        code = (kind < NUM_CODES) ? cmd_code[kind] : bbcs_pkg::t_byte'($urandom);
        send_item(bbcs_pkg::OP_WRITE, code);
        if (kind == bbcs_pkg::CFG_REG_READ) begin
            send_item(bbcs_pkg::OP_WRITE, bbcs_pkg::t_byte'($urandom));
        end
        if (kind == bbcs_pkg::CFG_REG_WRITE) begin
            send_item(bbcs_pkg::OP_WRITE, bbcs_pkg::t_byte'($urandom));
            send_item(bbcs_pkg::OP_WRITE, bbcs_pkg::t_byte'($urandom));
        end
        if ($urandom_range(0, 7) == 0) begin
            reads = $urandom_range(bbcs_pkg::REPLY_DEPTH - 2, bbcs_pkg::REPLY_DEPTH + 3);
        end else if (kind == bbcs_pkg::CFG_IDENT || kind == bbcs_pkg::CFG_SONAR) begin
            reads = $urandom_range(12, bbcs_pkg::ID_LEN + 4);
        end else begin
            reads = $urandom_range(0, 3);
        end
        repeat (reads) begin
            send_item(bbcs_pkg::OP_READ, bbcs_pkg::t_byte'($urandom));
        end
    endtask

    task automatic feed_packet();
        repeat ($urandom_range(bbcs_pkg::SYNC_RUN - 1, bbcs_pkg::FF_RUN_MAX + 2)) begin
            send_item(bbcs_pkg::OP_UART, bbcs_pkg::SYNC_BYTE);
        end
        repeat ($urandom_range(bbcs_pkg::PACKET_LEN - 3, bbcs_pkg::PACKET_LEN + 4)) begin
            send_item(bbcs_pkg::OP_UART, ($urandom_range(0, 5) == 0) ? bbcs_pkg::SYNC_BYTE
                                                                    : bbcs_pkg::t_byte'($urandom));
        end
    endtask

    task automatic random_step();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick < 11) begin
            issue_command($urandom_range(0, NUM_CODES));
        end else if (pick < 16) begin
            repeat ($urandom_range(1, 8)) begin
                send_item(bbcs_pkg::OP_UART, ($urandom_range(0, 3) == 0)
                          ? bbcs_pkg::SYNC_BYTE : bbcs_pkg::t_byte'($urandom));
            end
        end else if (pick < 18) begin
            send_item(bbcs_pkg::OP_READ, bbcs_pkg::t_byte'($urandom));
        end else begin
            send_item(OP_NONE, bbcs_pkg::t_byte'($urandom));
        end
    endtask

    task automatic test_directed_commands();
        send_item(bbcs_pkg::OP_READ, 8'h00);
        send_item(bbcs_pkg::OP_WRITE, cmd_code[bbcs_pkg::CFG_PING]);
        send_item(bbcs_pkg::OP_READ, 8'hFF);
        send_item(bbcs_pkg::OP_WRITE, cmd_code[bbcs_pkg::CFG_IDENT]);
        send_item(bbcs_pkg::OP_READ, 8'h00);
        send_item(bbcs_pkg::OP_READ, 8'h00);
        send_item(bbcs_pkg::OP_WRITE, cmd_code[bbcs_pkg::CFG_REG_WRITE]);
        send_item(bbcs_pkg::OP_WRITE, 8'hFF);
        send_item(bbcs_pkg::OP_WRITE, 8'hA5);
        send_item(bbcs_pkg::OP_WRITE, cmd_code[bbcs_pkg::CFG_REG_READ]);
        send_item(bbcs_pkg::OP_WRITE, 8'h0F);
        send_item(bbcs_pkg::OP_READ, 8'h00);
        send_item(bbcs_pkg::OP_READ, 8'h00);
        send_item(bbcs_pkg::OP_WRITE, cmd_code[bbcs_pkg::CFG_BOARD_RESET]);
        send_item(bbcs_pkg::OP_WRITE, 8'hFF);
        send_item(OP_NONE, 8'hFF);
        send_item(bbcs_pkg::OP_UART, 8'h00);
        send_item(bbcs_pkg::OP_UART, 8'hFF);
        send_item(bbcs_pkg::OP_WRITE, cmd_code[bbcs_pkg::CFG_SONAR]);
        send_item(bbcs_pkg::OP_READ, 8'h00);
    endtask

    task automatic test_packet_sync();
        repeat (5) begin
            feed_packet();
            issue_command(bbcs_pkg::CFG_SONAR);
        end
    endtask

    task automatic test_register_file();
        repeat (15) begin
            issue_command(($urandom_range(0, 1) == 0) ? bbcs_pkg::CFG_REG_WRITE
                                                      : bbcs_pkg::CFG_REG_READ);
        end
    endtask

    task automatic test_reply_overrun();
        send_item(bbcs_pkg::OP_WRITE, cmd_code[bbcs_pkg::CFG_IDENT]);
        repeat (bbcs_pkg::REPLY_DEPTH + 2) begin
            send_item(bbcs_pkg::OP_READ, bbcs_pkg::t_byte'($urandom));
        end
        send_item(bbcs_pkg::OP_WRITE, cmd_code[bbcs_pkg::CFG_PING]);
        repeat (bbcs_pkg::REPLY_DEPTH + 2) begin
            send_item(bbcs_pkg::OP_READ, bbcs_pkg::t_byte'($urandom));
        end
    endtask

    task automatic test_code_settings();
        bbcs_pkg::t_byte val;
        int s;
        int k;
        for (s = 0; s < 5; s++) begin
            drain_responses();
            for (k = 0; k < 8; k++) begin
                case (s)
                    0: val = 8'hFF - bbcs_pkg::t_byte'(k);
                    1: val = 8'h00;
                    2: val = 8'h10 + bbcs_pkg::t_byte'(k / 2);
                    3: val = bbcs_pkg::t_byte'($urandom);
                    default: val = bbcs_pkg::t_byte'(k);
                endcase
                cfg_write(bbcs_pkg::CFG_IDX_W'(k), val);
            end
            repeat (4) begin
                random_step();
            end
        end
    endtask

    task automatic test_random_mix();
        repeat (20) begin
            random_step();
        end
        while (sent_items < ITEM_TARGET) begin
            random_step();
        end
    endtask

    always @(negedge i_clk) begin
        stall_tick <= stall_tick + 8'd1;
        case (stall_tick[7:6])
            2'd0: i_out_ready <= 1'b1;
            2'd1: i_out_ready <= 1'($urandom_range(0, 1));
            2'd2: i_out_ready <= (stall_tick[1:0] == 2'd0);
            default: i_out_ready <= ($urandom_range(0, 4) != 0);
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (awaited_responses.size() == 0) begin
                $error("result transaction with no expectation waiting");
                fail_count++;
            end else begin
                head = awaited_responses.pop_front();
                if (o_out_item.read_byte !== head.read_byte) begin
                    $error("read_byte: expected %0h, actual %0h",
                           head.read_byte, o_out_item.read_byte);
                    fail_count++;
                end
                if (o_out_item.read_overrun !== head.read_overrun) begin
                    $error("read_overrun: expected %0b, actual %0b",
                           head.read_overrun, o_out_item.read_overrun);
                    fail_count++;
                end
                if (o_out_item.reset_pulse !== head.reset_pulse) begin
                    $error("reset_pulse: expected %0b, actual %0b",
                           head.reset_pulse, o_out_item.reset_pulse);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        for (int k = 0; k < NUM_CODES; k++) begin
            cmd_code[k] = bbcs_pkg::t_byte'(k);
        end
        for (int k = 0; k < bbcs_pkg::REG_DEPTH; k++) begin
            regs[k] = '0;
        end
        for (int k = 0; k < bbcs_pkg::REPLY_DEPTH; k++) begin
            reply_mem[k] = '0;
        end
        for (int k = 0; k < bbcs_pkg::PACKET_LEN; k++) begin
            rx_mem[k] = '0;
            sonar_snap[k] = '0;
        end
        phase = bbcs_pkg::PH_TOP;
        arg_seen = 1'b0;
        wr_addr = '0;
        reply_rd = 0;
        ff_count = 0;
        rx_fill = 0;

        repeat (6) begin
            @(negedge i_clk);
        end
        i_rst_n <= 1'b1;

        test_directed_commands();
        test_packet_sync();
        test_register_file();
        test_reply_overrun();
        test_code_settings();
        test_random_mix();
        drain_responses();
        repeat (TAIL_CYCLES) begin
            @(posedge i_clk);
        end

        if (fail_count == 0 && awaited_responses.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
